// ===== src/call_count_hash_table_core_macros.svh =====
// Assertion macros for the call-count hash table core.
// Used by the top level. Needs no package.
`ifndef CALL_COUNT_HASH_TABLE_CORE_MACROS_SVH
`define CALL_COUNT_HASH_TABLE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CCHT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ccht assertion failed");

`define CCHT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("ccht forbidden condition seen");

`else

`define CCHT_ASSERT(lbl, clk, rst_n, prop)

`define CCHT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== src/ccht_pkg.sv =====
// Shared types and constants of the call-count hash table core.
// Used by the top level and the testbench; depends on nothing.
`default_nettype none

package ccht_pkg;

	localparam int TABLE_SLOTS = 16384;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int OCC_W       = SLOT_W + 1;
	localparam int HASH_SHIFT  = 13;

	localparam int SLOT_OUT_W  = 14;
	localparam int USED_W      = 15;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STOP_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_STOP_ENABLE = 1'b1;

	typedef struct packed {
		logic [31:0] routine;
		logic [31:0] first_seen;
		logic [63:0] count;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_CHECK
	} state_t;

	function automatic logic [SLOT_W-1:0] slot_hash(input logic [31:0] key);
		logic [31:0] mix;
		mix = key ^ (key >> HASH_SHIFT);
		return mix[SLOT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/ccht_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot table of the call-count hash table core; no dependencies.
`default_nettype none

module ccht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/call_count_hash_table_core.sv =====
// Top level of the call-count hash table core: sequencer, counters and outputs.
// Depends on ccht_pkg, ccht_ram and call_count_hash_table_core_macros.svh.
//
// A request on the input channel is either a call event (func = 0) with a
// routine offset and frame number, or a clear command (func = 1). Each
// request gives exactly one result on the output channel. A request is taken
// when in_valid is high and in_stall is low; a result is taken when out_valid
// is high and out_stall is low.
// A call event probes the slot table one slot at a time through the single
// read port of the table RAM: each probe is an address step (ST_ISSUE), then a
// registered read and compare (ST_CHECK), and the result is written into the
// output register at the last compare, once that register is free. A call that
// finds no slot walks all TABLE_SLOTS slots.
// A clear command, and also reset, sweeps the table one slot per cycle over
// all TABLE_SLOTS slots (16384 by default). During the sweep after reset
// no request is taken and no result is given; the clear command gives an
// all-zero result at the end of its sweep.
// While a result waits under out_stall the next request is still taken; the
// block holds its final step only when a second result would have to enter the
// output register before the first has left. Configuration writes are taken in
// any cycle.
`default_nettype none
`include "call_count_hash_table_core_macros.svh"

module call_count_hash_table_core
	import ccht_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  func,
	input  wire logic [31:0]           callee_offset,
	input  wire logic [31:0]           frame,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [SLOT_OUT_W-1:0]      slot_index,
	output logic [63:0]                entry_calls,
	output logic [31:0]                entry_first_frame,
	output logic                       new_entry,
	output logic                       table_miss,
	output logic                       overflow_sticky,
	output logic [63:0]                total_calls,
	output logic [USED_W-1:0]          used_entries,
	output logic                       stop_hit
);

	state_t              state_q, state_d;
	logic [SLOT_W-1:0]   clr_addr_q;
	logic                clr_reply_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [SLOT_W-1:0]   probes_q;
	logic [31:0]         key_q;
	logic [31:0]         frame_q;
	logic                stop_q;
	logic [63:0]         total_q;
	logic [OCC_W-1:0]    occ_q;
	logic                ovf_q;
	logic [31:0]         stop_offset_q;
	logic                stop_enable_q;
	logic                out_valid_q;

	logic                ram_we;
	logic [SLOT_W-1:0]   ram_waddr;
	entry_t              ram_wdata;
	entry_t              ram_rdata;

	logic                out_free;
	logic                acc_call;
	logic                acc_clear;
	logic                clr_step;
	logic                probe_next;
	logic                emit;
	logic                emit_clear;
	logic                wr_new;
	logic                miss;
	logic                slot_empty;
	logic                slot_match;
	logic                last_probe;
	logic [63:0]         count_inc;

	ccht_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot_q),
		.rdata (ram_rdata)
	);

	assign out_free   = !out_valid_q || !out_stall;
	assign slot_empty = (ram_rdata.count == 64'd0);
	assign slot_match = (ram_rdata.routine == key_q);
	assign last_probe = &probes_q;
	assign count_inc  = (&ram_rdata.count) ? ram_rdata.count : ram_rdata.count + 64'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		acc_call   = 1'b0;
		acc_clear  = 1'b0;
		clr_step   = 1'b0;
		probe_next = 1'b0;
		emit       = 1'b0;
		emit_clear = 1'b0;
		wr_new     = 1'b0;
		miss       = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = slot_q;
		ram_wdata  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				if (!(&clr_addr_q)) begin
					clr_step = 1'b1;
				end else if (!clr_reply_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					emit       = 1'b1;
					emit_clear = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (func) begin
						acc_clear = 1'b1;
						state_d   = ST_CLEAR;
					end else begin
						acc_call = 1'b1;
						state_d  = ST_ISSUE;
					end
				end
			end
			ST_ISSUE: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (slot_empty || slot_match || last_probe) begin
					if (out_free) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
						if (slot_empty) begin
							wr_new    = 1'b1;
							ram_we    = 1'b1;
							ram_wdata = '{routine: key_q, first_seen: frame_q, count: 64'd1};
						end else if (slot_match) begin
							ram_we    = 1'b1;
							ram_wdata = '{routine: ram_rdata.routine,
								first_seen: ram_rdata.first_seen, count: count_inc};
						end else begin
							miss = 1'b1;
						end
					end
				end else begin
					probe_next = 1'b1;
					state_d    = ST_ISSUE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q    <= '0;
			clr_reply_q   <= 1'b0;
			total_q       <= '0;
			occ_q         <= '0;
			ovf_q         <= 1'b0;
			stop_offset_q <= '0;
			stop_enable_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_STOP_OFFSET: stop_offset_q <= cfg_data;
					REG_STOP_ENABLE: stop_enable_q <= cfg_data[0];
				endcase
			end
			if (acc_clear) begin
				clr_addr_q  <= '0;
				clr_reply_q <= 1'b1;
				total_q     <= '0;
				occ_q       <= '0;
				ovf_q       <= 1'b0;
			end else if (clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (acc_call) begin
				total_q <= total_q + 64'd1;
			end
			if (wr_new) begin
				occ_q <= occ_q + 1'b1;
			end
			if (miss) begin
				ovf_q <= 1'b1;
			end
			out_valid_q <= emit || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (acc_call) begin
			slot_q   <= slot_hash(callee_offset);
			probes_q <= '0;
			key_q    <= callee_offset;
			frame_q  <= frame;
			stop_q   <= stop_enable_q && (callee_offset == stop_offset_q);
		end else if (probe_next) begin
			slot_q   <= slot_q + 1'b1;
			probes_q <= probes_q + 1'b1;
		end
		if (emit) begin
			if (emit_clear) begin
				slot_index        <= '0;
				entry_calls       <= '0;
				entry_first_frame <= '0;
				new_entry         <= 1'b0;
				table_miss        <= 1'b0;
				overflow_sticky   <= 1'b0;
				total_calls       <= '0;
				used_entries      <= '0;
				stop_hit          <= 1'b0;
			end else begin
				slot_index        <= miss ? '0 : SLOT_OUT_W'(slot_q);
				entry_calls       <= miss ? 64'd0 : (wr_new ? 64'd1 : count_inc);
				entry_first_frame <= miss ? 32'd0 :
					(wr_new ? frame_q : ram_rdata.first_seen);
				new_entry         <= wr_new;
				table_miss        <= miss;
				overflow_sticky   <= ovf_q || miss;
				total_calls       <= total_q;
				used_entries      <= USED_W'(wr_new ? occ_q + 1'b1 : occ_q);
				stop_hit          <= stop_q;
			end
		end
	end

	assign out_valid = out_valid_q;

	`CCHT_ASSERT(a_miss_sets_sticky, clk, arst_n, out_valid_q && table_miss |-> overflow_sticky)
	`CCHT_ASSERT(a_new_entry_count_one, clk, arst_n, out_valid_q && new_entry |-> entry_calls == 64'd1)
	`CCHT_ASSERT(a_call_starts_probe, clk, arst_n, acc_call |=> state_q == ST_ISSUE)
	`CCHT_NEVER(a_occ_bounded, clk, arst_n, occ_q > OCC_W'(TABLE_SLOTS))

endmodule

`default_nettype wire

// ===== sim/tb_call_count_hash_table_core.sv =====
// Self-checking testbench for call_count_hash_table_core: directed rows, a probe-chain pass
// and randomized phases with idle and stall pressure, checked by fixed rows or a bench model.
// Depends on ccht_pkg and the core RTL.
`default_nettype none

module tb_call_count_hash_table_core
	import ccht_pkg::*;
();

	localparam logic FN_CALL  = 1'b0;
	localparam logic FN_CLEAR = 1'b1;
	localparam int   POOL_N   = 24;
	localparam int   FILL_N   = 64;
	localparam int   DRAIN_MAX = 200000;

	typedef struct packed {
		logic [SLOT_OUT_W-1:0] slot;
		logic [63:0]           calls;
		logic [31:0]           first;
		logic                  fresh;
		logic                  miss;
		logic                  ovf;
		logic [63:0]           total;
		logic [USED_W-1:0]     used;
		logic                  stop;
	} call_result_t;

	typedef struct packed {
		logic         fn;
		logic [31:0]  key;
		logic [31:0]  frm;
		logic         typed;
		call_result_t want;
	} call_row_t;

	// The stop offset is 0xFFFFFFFF and armed while these rows run.
	localparam call_row_t DIRECTED_ROWS [16] = '{
		'{fn: FN_CALL, key: 32'h0000_0000, frm: 32'h0000_0000, typed: 1'b1,
			want: '{slot: 0, calls: 1, first: 0, fresh: 1, miss: 0, ovf: 0,
				total: 1, used: 1, stop: 0}},
		'{fn: FN_CALL, key: 32'h0000_0000, frm: 32'hFFFF_FFFF, typed: 1'b1,
			want: '{slot: 0, calls: 2, first: 0, fresh: 0, miss: 0, ovf: 0,
				total: 2, used: 1, stop: 0}},
		'{fn: FN_CALL, key: 32'hFFFF_FFFF, frm: 32'hFFFF_FFFF, typed: 1'b1,
			want: '{slot: 1, calls: 1, first: 32'hFFFF_FFFF, fresh: 1, miss: 0, ovf: 0,
				total: 3, used: 2, stop: 1}},
		'{fn: FN_CALL, key: 32'h0000_0001, frm: 32'h0000_0005, typed: 1'b0, want: '0},
		'{fn: FN_CALL, key: 32'h0000_3FFE, frm: 32'h1234_5678, typed: 1'b0, want: '0},
		'{fn: FN_CALL, key: 32'h0000_7FFC, frm: 32'h0000_ABCD, typed: 1'b0, want: '0},
		'{fn: FN_CALL, key: 32'h0000_7FFC, frm: 32'hFFFF_FFFF, typed: 1'b0, want: '0},
		'{fn: FN_CALL, key: 32'hAAAA_AAAA, frm: 32'h5555_5555, typed: 1'b0, want: '0},
		'{fn: FN_CALL, key: 32'h5555_5555, frm: 32'hAAAA_AAAA, typed: 1'b0, want: '0},
		'{fn: FN_CALL, key: 32'hFFFF_FFFF, frm: 32'h0000_0000, typed: 1'b0, want: '0},
		'{fn: FN_CLEAR, key: 32'hFFFF_FFFF, frm: 32'hFFFF_FFFF, typed: 1'b1, want: '0},
		'{fn: FN_CALL, key: 32'hFFFF_FFFF, frm: 32'h0000_0007, typed: 1'b1,
			want: '{slot: 0, calls: 1, first: 7, fresh: 1, miss: 0, ovf: 0,
				total: 1, used: 1, stop: 1}},
		'{fn: FN_CALL, key: 32'h0000_0000, frm: 32'h8000_0000, typed: 1'b1,
			want: '{slot: 1, calls: 1, first: 32'h8000_0000, fresh: 1, miss: 0, ovf: 0,
				total: 2, used: 2, stop: 0}},
		'{fn: FN_CALL, key: 32'h8000_0000, frm: 32'hFFFF_FFFF, typed: 1'b0, want: '0},
		'{fn: FN_CLEAR, key: 32'h0000_0000, frm: 32'h0000_0000, typed: 1'b1, want: '0},
		'{fn: FN_CLEAR, key: 32'h0000_0000, frm: 32'h0000_0000, typed: 1'b1, want: '0}
	};

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  func = FN_CALL;
	logic [31:0]           callee_offset = '0;
	logic [31:0]           frame = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [63:0]           entry_calls;
	logic [31:0]           entry_first_frame;
	logic                  new_entry;
	logic                  table_miss;
	logic                  overflow_sticky;
	logic [63:0]           total_calls;
	logic [USED_W-1:0]     used_entries;
	logic                  stop_hit;

	bit [31:0] slot_routine [TABLE_SLOTS];
	bit [31:0] slot_first [TABLE_SLOTS];
	bit [63:0] slot_count [TABLE_SLOTS];
	bit [63:0] calls_seen;
	int        occupied;
	bit        overflowed;
	bit [31:0] stop_key;
	bit        stop_armed;

	call_result_t pending_results [$];
	int           mismatch_count = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;

	call_count_hash_table_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.callee_offset(callee_offset),
		.frame(frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.slot_index(slot_index),
		.entry_calls(entry_calls),
		.entry_first_frame(entry_first_frame),
		.new_entry(new_entry),
		.table_miss(table_miss),
		.overflow_sticky(overflow_sticky),
		.total_calls(total_calls),
		.used_entries(used_entries),
		.stop_hit(stop_hit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("tb_call_count_hash_table_core failed");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic call_result_t count_call(logic fn, logic [31:0] key, logic [31:0] frm);
		call_result_t      r;
		logic [SLOT_W-1:0] s;
		bit                placed;
		int                n;
		r = '0;
		placed = 1'b0;
		if (fn == FN_CLEAR) begin
			foreach (slot_count[i]) begin
				slot_count[i] = '0;
				slot_routine[i] = '0;
				slot_first[i] = '0;
			end
			calls_seen = '0;
			occupied = 0;
			overflowed = 1'b0;
			return r;
		end
		r.stop = stop_armed && (key == stop_key);
		calls_seen = calls_seen + 64'd1;
		s = SLOT_W'(key ^ (key >> HASH_SHIFT));
		for (n = 0; n < TABLE_SLOTS && !placed; n++) begin
			if (slot_count[s] == '0) begin
				slot_routine[s] = key;
				slot_first[s] = frm;
				slot_count[s] = 64'd1;
				occupied++;
				r.fresh = 1'b1;
				placed = 1'b1;
			end else if (slot_routine[s] == key) begin
				if (slot_count[s] != '1)
					slot_count[s] = slot_count[s] + 64'd1;
				placed = 1'b1;
			end else begin
				s = s + 1'b1;
			end
		end
		if (placed) begin
			r.slot = SLOT_OUT_W'(s);
			r.calls = slot_count[s];
			r.first = slot_first[s];
		end else begin
			overflowed = 1'b1;
			r.miss = 1'b1;
		end
		r.ovf = overflowed;
		r.total = calls_seen;
		r.used = USED_W'(occupied);
		return r;
	endfunction

	// Builds an offset whose hash lands exactly on slot h.
	function automatic logic [31:0] key_near_slot(logic [SLOT_W-1:0] h);
		logic [31:0] k;
		k = $urandom;
		k[26] = k[13] ^ h[13];
		k[12:0] = h[12:0] ^ k[25:13];
		return k;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STOP_OFFSET)
			stop_key = d;
		else if (idx == REG_STOP_ENABLE)
			stop_armed = d[0];
		@(posedge clk);
	endtask

	task automatic send_request(call_row_t row);
		call_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= row.fn;
		callee_offset <= row.key;
		frame <= row.frm;
		do
			@(posedge clk);
		while (in_stall);
		r = count_call(row.fn, row.key, row.frm);
		pending_results.push_back(row.typed ? row.want : r);
	endtask

	task automatic settle();
		int w;
		in_valid <= 1'b0;
		for (w = 0; w < DRAIN_MAX && pending_results.size() != 0; w++)
			@(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatch_count++;
		end
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin : check_results
		call_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no request pending");
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (slot_index !== want.slot) begin
					$error("slot_index: expected %0d, got %0d", want.slot, slot_index);
					mismatch_count++;
				end
				if (entry_calls !== want.calls) begin
					$error("entry_calls: expected %0d, got %0d", want.calls, entry_calls);
					mismatch_count++;
				end
				if (entry_first_frame !== want.first) begin
					$error("entry_first_frame: expected %h, got %h", want.first,
						entry_first_frame);
					mismatch_count++;
				end
				if (new_entry !== want.fresh) begin
					$error("new_entry: expected %0d, got %0d", want.fresh, new_entry);
					mismatch_count++;
				end
				if (table_miss !== want.miss) begin
					$error("table_miss: expected %0d, got %0d", want.miss, table_miss);
					mismatch_count++;
				end
				if (overflow_sticky !== want.ovf) begin
					$error("overflow_sticky: expected %0d, got %0d", want.ovf,
						overflow_sticky);
					mismatch_count++;
				end
				if (total_calls !== want.total) begin
					$error("total_calls: expected %0d, got %0d", want.total, total_calls);
					mismatch_count++;
				end
				if (used_entries !== want.used) begin
					$error("used_entries: expected %0d, got %0d", want.used, used_entries);
					mismatch_count++;
				end
				if (stop_hit !== want.stop) begin
					$error("stop_hit: expected %0d, got %0d", want.stop, stop_hit);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		call_row_t   row;
		logic [31:0] pool [POOL_N];
		logic [SLOT_W-1:0] base;
		int          choice;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(REG_STOP_OFFSET, 32'hFFFF_FFFF);
		write_reg(REG_STOP_ENABLE, 32'h0000_0001);

		foreach (DIRECTED_ROWS[i])
			send_request(DIRECTED_ROWS[i]);
		settle();

		// Fill a run of slots from slot zero, then send offsets, two of which must probe past it.
		write_reg(REG_STOP_OFFSET, 32'h8000_0000);
		send_request('{fn: FN_CLEAR, key: '0, frm: '0, typed: 1'b0, want: '0});
		for (int k = 0; k < FILL_N; k++)
			send_request('{fn: FN_CALL, key: k, frm: $urandom, typed: 1'b0, want: '0});
		send_request('{fn: FN_CALL, key: 32'hFFFF_FFFF, frm: 32'h0, typed: 1'b0, want: '0});
		send_request('{fn: FN_CALL, key: 32'h0000_1234, frm: 32'h1, typed: 1'b0, want: '0});
		send_request('{fn: FN_CALL, key: 32'h8000_0000, frm: 32'h2, typed: 1'b0, want: '0});
		send_request('{fn: FN_CLEAR, key: '0, frm: '0, typed: 1'b0, want: '0});
		send_request('{fn: FN_CALL, key: 32'h8000_0000, frm: 32'h3, typed: 1'b0, want: '0});
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 65; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 65; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			base = (phase == 0) ? SLOT_W'(TABLE_SLOTS - 4) : SLOT_W'($urandom);
			foreach (pool[i])
				pool[i] = key_near_slot(base + SLOT_W'($urandom_range(7)));
			write_reg(REG_STOP_OFFSET, (phase == 0) ? 32'h0 : pool[0]);
			write_reg(REG_STOP_ENABLE, ($urandom & ~32'h1) | (phase != 1));
			for (int n = 0; n < 300; n++) begin
				choice = $urandom_range(999);
				row = '{fn: FN_CALL, key: pool[$urandom_range(POOL_N - 1)], frm: $urandom,
					typed: 1'b0, want: '0};
				if (choice < 5)
					row.fn = FN_CLEAR;
				else if (choice < 100)
					row.key = $urandom;
				else if (choice < 180)
					row.key = stop_key;
				send_request(row);
			end
			settle();
		end

		if (mismatch_count == 0)
			$display("tb_call_count_hash_table_core passed");
		else
			$display("tb_call_count_hash_table_core failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+src
src/ccht_pkg.sv
src/ccht_ram.sv
src/call_count_hash_table_core.sv
sim/tb_call_count_hash_table_core.sv
